// ===== src/acss_pkg.sv =====
// acss_pkg: shared types, constants and segment decode for the alarm clock block
// no dependencies; used by acss_state, acss_disp and alarm_clock_seven_segment
`default_nettype none

package acss_pkg;

  // seconds in one day
  localparam logic [16:0] DAY_SEC = 17'd86400;

  // configuration register indexes and reset values
  localparam logic CFG_TICKS_PER_SECOND = 1'b0;
  localparam logic CFG_BEEP_WINDOW      = 1'b1;
  localparam logic [7:0]  TPS_RESET  = 8'd20;
  localparam logic [11:0] BEEP_RESET = 12'd60;

  // request commands
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_KEY  = 1'b1;

  // keypad codes
  localparam logic [3:0] KEY_TIME_1      = 4'd0;
  localparam logic [3:0] KEY_TIME_60     = 4'd1;
  localparam logic [3:0] KEY_TIME_3600   = 4'd2;
  localparam logic [3:0] KEY_ALARM_1     = 4'd3;
  localparam logic [3:0] KEY_ALARM_60    = 4'd4;
  localparam logic [3:0] KEY_ALARM_3600  = 4'd5;
  localparam logic [3:0] KEY_TOGGLE      = 4'd6;
  localparam logic [3:0] KEY_TIME_10     = 4'd7;
  localparam logic [3:0] KEY_TIME_600    = 4'd8;
  localparam logic [3:0] KEY_TIME_36000  = 4'd9;
  localparam logic [3:0] KEY_ALARM_10    = 4'd10;
  localparam logic [3:0] KEY_ALARM_600   = 4'd11;
  localparam logic [3:0] KEY_ALARM_3600B = 4'd12;

  typedef struct packed {
    logic       command;
    logic [3:0] key;
  } in_t;

  typedef struct packed {
    logic [6:0] hour_tens_seg;
    logic [6:0] hour_units_seg;
    logic [6:0] minute_tens_seg;
    logic [6:0] minute_units_seg;
    logic [6:0] second_tens_seg;
    logic [6:0] second_units_seg;
    logic       beep_on;
    logic       alarm_shown;
  } out_t;

  // clock value split into display fields, hours kept binary (0..24)
  typedef struct packed {
    logic [4:0] hour;
    logic [2:0] min_tens;
    logic [3:0] min_units;
    logic [2:0] sec_tens;
    logic [3:0] sec_units;
  } hms_t;

  // state seen by the display stage
  typedef struct packed {
    logic [16:0] time_sec;
    logic [16:0] alarm_sec;
    hms_t        time_hms;
    hms_t        alarm_hms;
    logic        show_alarm;
  } view_t;

  // segment pattern, bit 0 = segment a, blank for non-decimal codes
  function automatic logic [6:0] seg7(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h3f;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5b;
      4'd3:    s = 7'h4f;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6d;
      4'd6:    s = 7'h7d;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7f;
      4'd9:    s = 7'h6f;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== src/alarm_clock_seven_segment.sv =====
// alarm_clock_seven_segment: top level, configuration registers and the two stages
// depends on acss_pkg, acss_state, acss_disp
`default_nettype none

// Clock of day with alarm and a six-digit seven-segment readout (hh:mm:ss).
// Each request is a base tick (command 0) or a keypad key (command 1); every
// request gives exactly one result with the digits of the shown value after
// the update, the beep flag and which value is shown. One request is taken
// every cycle while in_ready is high. The state registers take a request
// as it is accepted, the result register takes its result when the output
// is free; while a result waits, one more request is taken into the state
// stage before the input stalls. Configuration: index 0 is ticks per second,
// index 1 the beep window in seconds; the user writes them only while the
// block is idle (not enforced). Reset shows 00:00:00, alarm at 24:00:00.
module alarm_clock_seven_segment (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire acss_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output acss_pkg::out_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire logic [11:0]    cfg_wdata
);

  logic [7:0]      tps_r;
  logic [11:0]     beep_window_r;
  logic            disp_valid;
  logic            disp_ready;
  acss_pkg::view_t view;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r         <= acss_pkg::TPS_RESET;
      beep_window_r <= acss_pkg::BEEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        acss_pkg::CFG_TICKS_PER_SECOND: tps_r         <= cfg_wdata[7:0];
        acss_pkg::CFG_BEEP_WINDOW:      beep_window_r <= cfg_wdata;
        default:                        ;
      endcase
    end
  end

  // time, alarm and prescaler state
  acss_state u_state (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .ticks_per_second (tps_r),
    .disp_ready       (disp_ready),
    .disp_valid       (disp_valid),
    .view             (view)
  );

  // readout and result register
  acss_disp u_disp (
    .clk         (clk),
    .rst_n       (rst_n),
    .disp_valid  (disp_valid),
    .disp_ready  (disp_ready),
    .view        (view),
    .beep_window (beep_window_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

// ===== src/acss_state.sv =====
// acss_state: prescaler, time and alarm registers, input handshake
// depends on acss_pkg
`default_nettype none

module acss_state (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire acss_pkg::in_t in_data,
  input  wire logic [7:0]    ticks_per_second,
  input  wire logic          disp_ready,
  output logic               disp_valid,
  output acss_pkg::view_t    view
);

  // digit position that a single adjustment touches
  localparam logic [2:0] POS_SU  = 3'd0;
  localparam logic [2:0] POS_ST  = 3'd1;
  localparam logic [2:0] POS_MU  = 3'd2;
  localparam logic [2:0] POS_MT  = 3'd3;
  localparam logic [2:0] POS_H1  = 3'd4;
  localparam logic [2:0] POS_H10 = 3'd5;

  // increment one position with carries, hours wrap at 24
  function automatic acss_pkg::hms_t hms_inc(input acss_pkg::hms_t v, input logic [2:0] pos);
    acss_pkg::hms_t r;
    logic           c;
    logic [5:0]     h;
    r = v;
    c = (pos == POS_SU);
    if (c) begin
      if (r.sec_units == 4'd9) r.sec_units = 4'd0;
      else begin r.sec_units = r.sec_units + 4'd1; c = 1'b0; end
    end
    c = c | (pos == POS_ST);
    if (c) begin
      if (r.sec_tens == 3'd5) r.sec_tens = 3'd0;
      else begin r.sec_tens = r.sec_tens + 3'd1; c = 1'b0; end
    end
    c = c | (pos == POS_MU);
    if (c) begin
      if (r.min_units == 4'd9) r.min_units = 4'd0;
      else begin r.min_units = r.min_units + 4'd1; c = 1'b0; end
    end
    c = c | (pos == POS_MT);
    if (c) begin
      if (r.min_tens == 3'd5) r.min_tens = 3'd0;
      else begin r.min_tens = r.min_tens + 3'd1; c = 1'b0; end
    end
    h = {1'b0, r.hour};
    if (c || pos == POS_H1) h = h + 6'd1;
    else if (pos == POS_H10) h = h + 6'd10;
    if (h >= 6'd24) h = h - 6'd24;
    r.hour = h[4:0];
    return r;
  endfunction

  // decrement one position with borrows, hours wrap below zero to 23
  function automatic acss_pkg::hms_t hms_dec(input acss_pkg::hms_t v, input logic [2:0] pos);
    acss_pkg::hms_t r;
    logic           b;
    r = v;
    b = (pos == POS_SU);
    if (b) begin
      if (r.sec_units == 4'd0) r.sec_units = 4'd9;
      else begin r.sec_units = r.sec_units - 4'd1; b = 1'b0; end
    end
    b = b | (pos == POS_ST);
    if (b) begin
      if (r.sec_tens == 3'd0) r.sec_tens = 3'd5;
      else begin r.sec_tens = r.sec_tens - 3'd1; b = 1'b0; end
    end
    b = b | (pos == POS_MU);
    if (b) begin
      if (r.min_units == 4'd0) r.min_units = 4'd9;
      else begin r.min_units = r.min_units - 4'd1; b = 1'b0; end
    end
    b = b | (pos == POS_MT);
    if (b) begin
      if (r.min_tens == 3'd0) r.min_tens = 3'd5;
      else begin r.min_tens = r.min_tens - 3'd1; b = 1'b0; end
    end
    if (b || pos == POS_H1) begin
      if (r.hour == 5'd0) r.hour = 5'd23;
      else r.hour = r.hour - 5'd1;
    end
    return r;
  endfunction

  logic [16:0]    time_r, time_nxt;
  logic [16:0]    alarm_r, alarm_nxt;
  acss_pkg::hms_t time_hms_r, time_hms_nxt;
  acss_pkg::hms_t alarm_hms_r, alarm_hms_nxt;
  logic [7:0]     tick_r, tick_nxt;
  logic           show_r, show_nxt;
  logic           pend_r, pend_nxt;

  logic           step;
  logic           do_add;
  logic           do_sub;
  logic           do_toggle;
  logic [2:0]     pos;
  logic [16:0]    amount;
  logic [7:0]     tick_inc;
  logic [17:0]    time_sum;
  logic [17:0]    alarm_wrap;

  // handshake: a new request may enter when none is pending or the pending one moves to the display
  assign in_ready   = !pend_r || disp_ready;
  assign step       = in_valid && in_ready;
  assign disp_valid = pend_r;
  assign pend_nxt   = step ? 1'b1 : (disp_ready ? 1'b0 : pend_r);

  // decode the request into one adjustment
  always_comb begin
    do_add    = 1'b0;
    do_sub    = 1'b0;
    do_toggle = 1'b0;
    pos       = POS_SU;
    amount    = 17'd0;
    tick_inc  = tick_r + 8'd1;
    tick_nxt  = tick_r;
    if (in_data.command == acss_pkg::CMD_TICK) begin
      if (tick_inc >= ticks_per_second) begin
        tick_nxt = 8'd0;
        do_add   = 1'b1;
        amount   = 17'd1;
      end else begin
        tick_nxt = tick_inc;
      end
    end else begin
      case (in_data.key)
        acss_pkg::KEY_TIME_1:      begin do_add = 1'b1; pos = POS_SU;  amount = 17'd1;     end
        acss_pkg::KEY_TIME_10:     begin do_add = 1'b1; pos = POS_ST;  amount = 17'd10;    end
        acss_pkg::KEY_TIME_60:     begin do_add = 1'b1; pos = POS_MU;  amount = 17'd60;    end
        acss_pkg::KEY_TIME_600:    begin do_add = 1'b1; pos = POS_MT;  amount = 17'd600;   end
        acss_pkg::KEY_TIME_3600:   begin do_add = 1'b1; pos = POS_H1;  amount = 17'd3600;  end
        acss_pkg::KEY_TIME_36000:  begin do_add = 1'b1; pos = POS_H10; amount = 17'd36000; end
        acss_pkg::KEY_ALARM_1:     begin do_sub = 1'b1; pos = POS_SU;  amount = 17'd1;     end
        acss_pkg::KEY_ALARM_10:    begin do_sub = 1'b1; pos = POS_ST;  amount = 17'd10;    end
        acss_pkg::KEY_ALARM_60:    begin do_sub = 1'b1; pos = POS_MU;  amount = 17'd60;    end
        acss_pkg::KEY_ALARM_600:   begin do_sub = 1'b1; pos = POS_MT;  amount = 17'd600;   end
        acss_pkg::KEY_ALARM_3600,
        acss_pkg::KEY_ALARM_3600B: begin do_sub = 1'b1; pos = POS_H1;  amount = 17'd3600;  end
        acss_pkg::KEY_TOGGLE:      do_toggle = 1'b1;
        default:                   ;
      endcase
    end
  end

  // binary seconds, kept alongside the display fields for the beep compare
  always_comb begin
    time_sum   = {1'b0, time_r} + {1'b0, amount};
    alarm_wrap = {1'b0, alarm_r} + {1'b0, acss_pkg::DAY_SEC} - {1'b0, amount};
    if (time_sum >= {1'b0, acss_pkg::DAY_SEC}) time_sum = time_sum - {1'b0, acss_pkg::DAY_SEC};

    time_nxt      = time_r;
    alarm_nxt     = alarm_r;
    time_hms_nxt  = time_hms_r;
    alarm_hms_nxt = alarm_hms_r;
    show_nxt      = show_r;
    if (do_add) begin
      time_nxt     = time_sum[16:0];
      time_hms_nxt = hms_inc(time_hms_r, pos);
    end
    if (do_sub) begin
      alarm_nxt     = (alarm_r >= amount) ? (alarm_r - amount) : alarm_wrap[16:0];
      alarm_hms_nxt = hms_dec(alarm_hms_r, pos);
    end
    if (do_toggle) show_nxt = !show_r;
  end

  // state registers, updated once per accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= 17'd0;
      alarm_r     <= acss_pkg::DAY_SEC;
      time_hms_r  <= '0;
      alarm_hms_r <= '{hour: 5'd24, min_tens: 3'd0, min_units: 4'd0,
                       sec_tens: 3'd0, sec_units: 4'd0};
      tick_r      <= 8'd0;
      show_r      <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (step) begin
        time_r      <= time_nxt;
        alarm_r     <= alarm_nxt;
        time_hms_r  <= time_hms_nxt;
        alarm_hms_r <= alarm_hms_nxt;
        tick_r      <= tick_nxt;
        show_r      <= show_nxt;
      end
    end
  end

  assign view = '{time_sec: time_r, alarm_sec: alarm_r, time_hms: time_hms_r,
                  alarm_hms: alarm_hms_r, show_alarm: show_r};

endmodule

`default_nettype wire

// ===== src/acss_disp.sv =====
// acss_disp: segment decode, beep compare and the result register
// depends on acss_pkg
`default_nettype none

module acss_disp (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            disp_valid,
  output logic                 disp_ready,
  input  wire acss_pkg::view_t view,
  input  wire logic [11:0]     beep_window,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output acss_pkg::out_t       out_data
);

  logic           out_valid_r, out_valid_nxt;
  acss_pkg::out_t out_data_r, out_data_nxt;
  acss_pkg::hms_t shown;
  logic [3:0]     hour_tens;
  logic [3:0]     hour_units;
  logic [17:0]    window_end;
  logic           load;

  assign disp_ready    = !out_valid_r || out_ready;
  assign load          = disp_valid && disp_ready;
  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // pick the shown value and split the hours into two digits
  always_comb begin
    shown = view.show_alarm ? view.alarm_hms : view.time_hms;
    if (shown.hour >= 5'd20) begin
      hour_tens  = 4'd2;
      hour_units = 4'(shown.hour - 5'd20);
    end else if (shown.hour >= 5'd10) begin
      hour_tens  = 4'd1;
      hour_units = 4'(shown.hour - 5'd10);
    end else begin
      hour_tens  = 4'd0;
      hour_units = shown.hour[3:0];
    end
  end

  // beep window is open strictly between alarm and alarm plus window
  assign window_end = {1'b0, view.alarm_sec} + {6'd0, beep_window};

  always_comb begin
    out_data_nxt.hour_tens_seg    = acss_pkg::seg7(hour_tens);
    out_data_nxt.hour_units_seg   = acss_pkg::seg7(hour_units);
    out_data_nxt.minute_tens_seg  = acss_pkg::seg7({1'b0, shown.min_tens});
    out_data_nxt.minute_units_seg = acss_pkg::seg7(shown.min_units);
    out_data_nxt.second_tens_seg  = acss_pkg::seg7({1'b0, shown.sec_tens});
    out_data_nxt.second_units_seg = acss_pkg::seg7(shown.sec_units);
    out_data_nxt.beep_on          = (view.time_sec > view.alarm_sec) &&
                                    ({1'b0, view.time_sec} < window_end);
    out_data_nxt.alarm_shown      = view.show_alarm;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
